@@ src/mabsg_pkg.sv @@
`timescale 1ns / 1ps
package mabsg_pkg;
    localparam int TGT_W   = 20;
    localparam int DUR_W   = 26;
    localparam int DLY_W   = 16;
    localparam int CNT_W   = 21;
    localparam int FRAC_W  = 9;
    localparam int QUO_W   = 27;
    localparam int NUM_W   = 35;

    localparam logic [1:0] ST_STEP    = 2'd0;
    localparam logic [1:0] ST_STARTED = 2'd1;
    localparam logic [1:0] ST_NOTHING = 2'd2;
    localparam logic [1:0] ST_ABORTED = 2'd3;

    localparam logic [1:0] CFG_CAL = 2'd0;
    localparam logic [1:0] CFG_INV = 2'd1;
    localparam logic [1:0] CFG_MIN = 2'd2;
    localparam logic [1:0] CFG_MAX = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_SETUP, S_MERGE, S_DIV_AVG, S_DIV_INIT, S_PROFILE,
        S_ADV_MUL, S_ADV_DIV, S_ADV_FIN, S_OUT
    } seq_state_t;

    typedef struct packed {
        logic start;
        logic load;
        logic step;
    } lane_ctrl_t;

    function automatic logic [DLY_W-1:0] clamp16(input logic [QUO_W:0] x,
                                                  input logic [DLY_W-1:0] lo,
                                                  input logic [DLY_W-1:0] hi);
        logic [QUO_W:0] lo_x;
        logic [QUO_W:0] hi_x;
        lo_x = {{(QUO_W+1-DLY_W){1'b0}}, lo};
        hi_x = {{(QUO_W+1-DLY_W){1'b0}}, hi};
        if (x < lo_x)      return lo;
        else if (x > hi_x) return hi;
        else               return x[DLY_W-1:0];
    endfunction
endpackage

@@ src/mabsg_divider.sv @@
`timescale 1ns / 1ps
module mabsg_divider (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [mabsg_pkg::NUM_W-1:0] numer,
    input  logic [mabsg_pkg::CNT_W-1:0] denom,
    output logic                        done,
    output logic [mabsg_pkg::NUM_W-1:0] quot
);
    import mabsg_pkg::*;

    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg, q_next;
    logic [CNT_W-1:0] r_reg, r_next;
    logic [CW-1:0]    n_reg, n_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W:0]   trial;

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        n_next    = n_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg, q_reg[NUM_W-1]};
        if (start) begin
            q_next    = numer;
            r_next    = '0;
            n_next    = CW'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // restoring, one quotient bit per cycle
            if (trial >= {1'b0, denom}) begin
                r_next = CNT_W'(trial - {1'b0, denom});
                q_next = {q_reg[NUM_W-2:0], 1'b1};
            end else begin
                r_next = trial[CNT_W-1:0];
                q_next = {q_reg[NUM_W-2:0], 1'b0};
            end
            n_next = n_reg - 1'b1;
            if (n_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
        r_reg <= r_next;
        n_reg <= n_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule

@@ src/mabsg_lane.sv @@
`timescale 1ns / 1ps
module mabsg_lane #(
    parameter int POSITION_BITS = 20
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  mabsg_pkg::lane_ctrl_t       ctrl,
    input  logic signed [mabsg_pkg::TGT_W-1:0] target,
    input  logic                        calibrated,
    input  logic                        invert,
    input  logic                        is_master,
    input  logic [mabsg_pkg::CNT_W-1:0] master_count,
    output logic [mabsg_pkg::CNT_W-1:0] distance,
    output logic                        moved,
    output logic                        dir_bit,
    output logic                        stepped
);
    import mabsg_pkg::*;

    localparam int DW = CNT_W + 3;
    localparam int PW = (POSITION_BITS > TGT_W ? POSITION_BITS : TGT_W) + 1;

    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0]         dist_reg, dist_next;
    logic                     neg_reg, neg_next;
    logic signed [DW-1:0]     dec_reg, dec_next;
    logic                     dir_reg, dir_next;
    logic                     stepped_reg, stepped_next;
    logic                     moved_reg, moved_next;
    logic signed [PW-1:0]     tgt_x, pos_x, d;
    logic [PW-1:0]            mag;
    logic                     stp;

    always_comb begin
        pos_next     = pos_reg;
        dist_next    = dist_reg;
        neg_next     = neg_reg;
        dec_next     = dec_reg;
        dir_next     = dir_reg;
        stepped_next = stepped_reg;
        moved_next   = moved_reg;
        tgt_x = calibrated ? PW'(target) : '0;
        pos_x = calibrated ? PW'($signed(pos_reg)) : '0;
        d     = tgt_x - pos_x;
        mag   = d[PW-1] ? PW'(-d) : PW'(d);
        stp   = is_master || !dec_reg[DW-1];
        if (ctrl.start) begin
            if (!calibrated) pos_next = '0;
            neg_next   = d[PW-1];
            dist_next  = CNT_W'(mag);
            moved_next = (d != '0);
            if (d != '0) dir_next = d[PW-1] ^ invert;
        end
        if (ctrl.load)
            dec_next = DW'({1'b0, dist_reg, 1'b0}) - DW'({1'b0, master_count});
        if (ctrl.step) begin
            stepped_next = stp;
            if (!is_master) begin
                dec_next = dec_reg + DW'({1'b0, dist_reg, 1'b0})
                         - (stp ? DW'({1'b0, master_count, 1'b0}) : '0);
            end
            if (stp) pos_next = neg_reg ? pos_reg - 1'b1 : pos_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            dist_reg    <= '0;
            neg_reg     <= 1'b0;
            dec_reg     <= '0;
            dir_reg     <= 1'b0;
            stepped_reg <= 1'b0;
            moved_reg   <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            dist_reg    <= dist_next;
            neg_reg     <= neg_next;
            dec_reg     <= dec_next;
            dir_reg     <= dir_next;
            stepped_reg <= stepped_next;
            moved_reg   <= moved_next;
        end
    end

    assign distance = dist_reg;
    assign moved    = moved_reg;
    assign dir_bit  = dir_reg;
    assign stepped  = stepped_reg;
endmodule

@@ src/multi_axis_bresenham_step_generator_unit.sv @@
`timescale 1ns / 1ps
// Channel | Dir | Contents
// s_axis  | in  | tdata: targets a..f, duration, ramp fraction, estop; tuser: mode
// m_axis  | out | tdata: step_mask, dir_levels, delay_us; tlast: last_step; tuser: status
// cfg     | in  | cfg_we / cfg_index / cfg_data, register write, no read-back
// Start word: setup, merge, then two divides in the shared restoring
//   divider; no divide when every axis is still.
// Advance word: one profile divide on a ramp step, none on a cruise step
//   or when idle or aborted.
// One word in flight at a time; the result waits in S_OUT while the output
// register is still full, and s_tready returns when it moves there.
// aresetn is synchronous, active low; all axis state and control registers reset.
module multi_axis_bresenham_step_generator_unit #(
    parameter int AXES          = 6,
    parameter int POSITION_BITS = 20
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata low->high: target_a..target_f[119:0], duration_us[145:120],
    // ramp_fraction[154:146], estop[155], zero pad
    input  logic [159:0] s_tdata,
    input  logic         s_tuser,   // mode
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata low->high: step_mask[5:0], dir_levels[11:6], delay_us[27:12], pad
    output logic [31:0]  m_tdata,
    output logic         m_tlast,   // last_step
    output logic [1:0]   m_tuser,   // status
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);
    import mabsg_pkg::*;

    localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;

    seq_state_t state_reg, state_next;
    logic [5:0]  cal_reg, inv_reg;
    logic [DLY_W-1:0] min_reg, max_reg;
    logic [159:0] in_reg;
    logic        mode_reg;
    logic [AW-1:0]    mi_reg, mi_next;
    logic [CNT_W-1:0] mc_reg, mc_next, si_reg, si_next, rs_reg, rs_next;
    logic [DLY_W-1:0] cru_reg, cru_next, sd_reg, sd_next;
    logic        moving_reg, moving_next;
    logic [NUM_W-1:0] numer_reg, numer_next;
    logic [CNT_W-1:0] den_reg, den_next;
    logic        div_go_reg, div_go_next;
    logic        div_done;
    logic [NUM_W-1:0] quot;
    logic        dec_phase_reg, dec_phase_next;
    logic        ovalid_reg, ovalid_next;
    logic [31:0] odata_reg, odata_next;
    logic        olast_reg, olast_next;
    logic [1:0]  ouser_reg, ouser_next;
    logic [31:0] res_data_reg, res_data_next;
    logic        res_last_reg, res_last_next;
    logic [1:0]  res_user_reg, res_user_next;
    logic        any_moved;
    logic [AXES-1:0] dirv, stepv, movedv;
    logic [CNT_W-1:0] lane_dist [AXES];
    lane_ctrl_t  lctl;
    logic [8:0]  frac;
    logic [DLY_W-1:0] diff_mag, dly_raw;
    logic        neg_diff;
    logic [CNT_W-1:0] decel_at, ramp_k, rs_m1;
    logic [DLY_W+CNT_W-1:0] ramp_prod;
    logic [5:0]  dir6, step6;
    logic [DLY_W-1:0] adv_dly_reg, adv_dly_next;
    logic        last_c;

    function automatic logic signed [TGT_W-1:0] s_tdata_reg_sel(input int k);
        return in_reg[k*TGT_W +: TGT_W];
    endfunction

    // per-axis lanes
    for (genvar g = 0; g < AXES; g++) begin : g_lane
        logic signed [TGT_W-1:0] tgt;
        logic cal, inv;
        if (g < 6) begin : g_f
            assign tgt = s_tdata_reg_sel(g);
            assign cal = cal_reg[g];
            assign inv = inv_reg[g];
        end else begin : g_z
            assign tgt = '0;
            assign cal = 1'b0;
            assign inv = 1'b0;
        end
        mabsg_lane #(.POSITION_BITS(POSITION_BITS)) u_lane (
            .aclk, .aresetn, .ctrl(lctl), .target(tgt), .calibrated(cal),
            .invert(inv), .is_master(mi_reg == AW'(g)), .master_count(mc_reg),
            .distance(lane_dist[g]), .moved(movedv[g]), .dir_bit(dirv[g]),
            .stepped(stepv[g]));
    end

    mabsg_divider u_div (
        .aclk, .aresetn, .start(div_go_reg), .numer(numer_reg), .denom(den_reg),
        .done(div_done), .quot(quot));

    always_comb begin
        dir6  = '0;
        step6 = '0;
        for (int i = 0; i < AXES && i < 6; i++) begin
            dir6[i]  = dirv[i];
            step6[i] = stepv[i];
        end
        any_moved = |movedv;
    end

    assign frac     = (in_reg[154:146] > 9'd256) ? 9'd256 : in_reg[154:146];
    // start delay sits below cruise only when min_delay_us exceeds max_delay_us
    assign neg_diff = sd_reg < cru_reg;
    assign diff_mag = neg_diff ? cru_reg - sd_reg : sd_reg - cru_reg;
    assign decel_at = mc_reg - rs_reg;
    assign rs_m1    = rs_reg - 1'b1;
    assign ramp_k   = (si_reg < rs_reg) ? si_reg : si_reg - decel_at;
    assign ramp_prod = diff_mag * ramp_k;
    assign last_c   = (si_reg + 1'b1) >= mc_reg;

    always_comb begin
        state_next     = state_reg;
        mi_next        = mi_reg;
        mc_next        = mc_reg;
        si_next        = si_reg;
        rs_next        = rs_reg;
        cru_next       = cru_reg;
        sd_next        = sd_reg;
        moving_next    = moving_reg;
        numer_next     = numer_reg;
        den_next       = den_reg;
        div_go_next    = 1'b0;
        dec_phase_next = dec_phase_reg;
        adv_dly_next   = adv_dly_reg;
        ovalid_next    = ovalid_reg;
        odata_next     = odata_reg;
        olast_next     = olast_reg;
        ouser_next     = ouser_reg;
        res_data_next  = res_data_reg;
        res_last_next  = res_last_reg;
        res_user_next  = res_user_reg;
        lctl           = '0;
        dly_raw        = cru_reg;
        if (ovalid_reg && m_tready) ovalid_next = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = s_tuser ? S_ADV_MUL : S_SETUP;
            end
            S_SETUP: begin
                lctl.start = 1'b1;
                state_next = S_MERGE;
            end
            S_MERGE: begin
                // merge lanes: first axis with largest distance
                mi_next = '0;
                mc_next = lane_dist[0];
                for (int i = 1; i < AXES; i++)
                    if (lane_dist[i] > mc_next) begin
                        mc_next = lane_dist[i];
                        mi_next = AW'(i);
                    end
                si_next     = '0;
                moving_next = 1'b0;
                if (!any_moved) begin
                    rs_next       = '0;
                    res_data_next = {4'd0, DLY_W'(0), dir6, 6'd0};
                    res_last_next = 1'b0;
                    res_user_next = ST_NOTHING;
                    state_next    = S_OUT;
                end else begin
                    rs_next     = CNT_W'((30'(mc_next) * 30'(frac)) >> 9);
                    numer_next  = NUM_W'(in_reg[145:120]);
                    den_next    = mc_next;
                    div_go_next = 1'b1;
                    state_next  = S_DIV_AVG;
                end
            end
            S_DIV_AVG: begin
                if (div_done) begin
                    lctl.load   = 1'b1;
                    cru_next    = clamp16(quot[QUO_W:0], min_reg, max_reg);
                    // (dur*(256+f))>>8 / mc equals dur*(256+f) / (256*mc)
                    numer_next  = NUM_W'((NUM_W'(in_reg[145:120]) * NUM_W'(10'(frac) + 10'd256))
                                  >> 8);
                    div_go_next = 1'b1;
                    state_next  = S_DIV_INIT;
                end
            end
            S_DIV_INIT: begin
                if (div_done) begin
                    sd_next       = clamp16(quot[QUO_W:0], cru_reg, max_reg);
                    moving_next   = 1'b1;
                    res_data_next = {4'd0, DLY_W'(0), dir6, 6'd0};
                    res_last_next = 1'b0;
                    res_user_next = ST_STARTED;
                    state_next    = S_OUT;
                end
            end
            S_ADV_MUL: begin
                if (!moving_reg) begin
                    res_data_next = {4'd0, DLY_W'(0), dir6, 6'd0};
                    res_last_next = 1'b0;
                    res_user_next = ST_NOTHING;
                    state_next    = S_OUT;
                end else if (in_reg[155]) begin
                    moving_next   = 1'b0;
                    res_data_next = {4'd0, DLY_W'(0), dir6, 6'd0};
                    res_last_next = 1'b0;
                    res_user_next = ST_ABORTED;
                    state_next    = S_OUT;
                end else if (rs_reg != '0 && si_reg < rs_reg) begin
                    // accel: ceil of |diff|*s/rs; when diff is negative, (|diff|*s - (rs-1))/rs, floored at zero
                    if (!neg_diff)
                        numer_next = NUM_W'(ramp_prod) + NUM_W'(rs_m1);
                    else if (ramp_prod >= (DLY_W+CNT_W)'(rs_m1))
                        numer_next = NUM_W'(ramp_prod - (DLY_W+CNT_W)'(rs_m1));
                    else
                        numer_next = '0;
                    den_next       = rs_reg;
                    dec_phase_next = 1'b0;
                    div_go_next    = 1'b1;
                    state_next     = S_ADV_DIV;
                end else if (rs_reg != '0 && si_reg >= decel_at) begin
                    numer_next     = NUM_W'(ramp_prod);
                    den_next       = rs_reg;
                    dec_phase_next = 1'b1;
                    div_go_next    = 1'b1;
                    state_next     = S_ADV_DIV;
                end else begin
                    adv_dly_next = clamp16(28'(cru_reg), min_reg, max_reg);
                    lctl.step    = 1'b1;
                    state_next   = S_ADV_FIN;
                end
            end
            S_ADV_DIV: begin
                if (div_done) begin
                    if (dec_phase_reg)
                        dly_raw = neg_diff ? cru_reg - quot[DLY_W-1:0]
                                           : cru_reg + quot[DLY_W-1:0];
                    else
                        dly_raw = neg_diff ? sd_reg + quot[DLY_W-1:0]
                                           : sd_reg - quot[DLY_W-1:0];
                    adv_dly_next = clamp16(28'(dly_raw), min_reg, max_reg);
                    lctl.step    = 1'b1;
                    state_next   = S_ADV_FIN;
                end
            end
            S_ADV_FIN: begin
                si_next = si_reg + 1'b1;
                if (last_c) moving_next = 1'b0;
                res_data_next = {4'd0, adv_dly_reg, dir6, step6};
                res_last_next = last_c;
                res_user_next = ST_STEP;
                state_next    = S_OUT;
            end
            S_OUT: begin
                if (!ovalid_reg || m_tready) begin
                    ovalid_next = 1'b1;
                    odata_next  = res_data_reg;
                    olast_next  = res_last_reg;
                    ouser_next  = res_user_reg;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg   <= s_tdata;
            mode_reg <= s_tuser;
        end
        numer_reg     <= numer_next;
        den_reg       <= den_next;
        dec_phase_reg <= dec_phase_next;
        adv_dly_reg   <= adv_dly_next;
        odata_reg     <= odata_next;
        olast_reg     <= olast_next;
        ouser_reg     <= ouser_next;
        res_data_reg  <= res_data_next;
        res_last_reg  <= res_last_next;
        res_user_reg  <= res_user_next;
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            cal_reg    <= '0;
            inv_reg    <= 6'd63;
            min_reg    <= 16'd50;
            max_reg    <= 16'd10000;
            mi_reg     <= '0;
            mc_reg     <= '0;
            si_reg     <= '0;
            rs_reg     <= '0;
            cru_reg    <= '0;
            sd_reg     <= '0;
            moving_reg <= 1'b0;
            div_go_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mi_reg     <= mi_next;
            mc_reg     <= mc_next;
            si_reg     <= si_next;
            rs_reg     <= rs_next;
            cru_reg    <= cru_next;
            sd_reg     <= sd_next;
            moving_reg <= moving_next;
            div_go_reg <= div_go_next;
            ovalid_reg <= ovalid_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_CAL: cal_reg <= cfg_data[5:0];
                    CFG_INV: inv_reg <= cfg_data[5:0];
                    CFG_MIN: min_reg <= cfg_data;
                    CFG_MAX: max_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tlast  = olast_reg;
    assign m_tuser  = ouser_reg;

`ifndef SYNTH
    a_idle_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_STEP) |-> (m_tdata[5:0] == 6'd0))
        else $error("step mask set on non-step word");
    a_last_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ADV_FIN && last_c) |=> !moving_reg)
        else $error("move still active after last step");
    a_step_master: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ADV_FIN) |-> stepv[mi_reg])
        else $error("master axis did not step");
    a_mode_path: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ADV_MUL) |-> mode_reg)
        else $error("advance path on start word");
`endif
endmodule
